>>> sv/thrc_pkg.sv
// Shared types and constants for the touch hold/repeat classifier.
`timescale 1ns / 1ps

package thrc_pkg;

    localparam int unsigned COORD_W   = 16;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned PCOUNT_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // Hold counter restarts at one once it would pass this value
    localparam logic [COUNT_W-1:0] COUNT_WRAP = 16'd64999;

    localparam logic [COUNT_W-1:0] DOWN_DELAY_RST    = 16'd2;
    localparam logic [COUNT_W-1:0] HOLD_DELAY_RST    = 16'd25;
    localparam logic [COUNT_W-1:0] REPEAT_PERIOD_RST = 16'd5;

    localparam logic [CFG_IDX_W-1:0] REG_DOWN_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd2;

    typedef enum logic [2:0] {
        EV_DOWN      = 3'd0,
        EV_HOLD      = 3'd1,
        EV_REPEAT    = 3'd2,
        EV_UP_BEFORE = 3'd3,
        EV_UP_AFTER  = 3'd4,
        EV_NONE      = 3'd7
    } event_kind_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } result_t;

endpackage

>>> sv/touch_hold_repeat_classifier_core.sv
// Touch poll classifier: DOWN / HOLD / REPEAT / release events from poll ticks.
// A tick's event goes to the output register, or to the skid entry while out_stall holds.
// One tick per cycle with the skid entry empty; per-tick work is 16-bit compares, increments.
// Output register plus one skid entry: input stalls only while the skid entry is occupied.
// Reset (rst_n, async, active low): counters and coordinates cleared, no stored event,
// registers back to down_delay 2, hold_delay 25, repeat_period 5, output empty.
`timescale 1ns / 1ps

module touch_hold_repeat_classifier_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // poll tick channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [thrc_pkg::PCOUNT_W-1:0]     point_count,
    input  logic [thrc_pkg::COORD_W-1:0]      touch_x,
    input  logic [thrc_pkg::COORD_W-1:0]      touch_y,
    // event channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        event_kind,
    output logic [thrc_pkg::COORD_W-1:0]      event_x,
    output logic [thrc_pkg::COORD_W-1:0]      event_y,
    // register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [thrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [thrc_pkg::COUNT_W-1:0]      cfg_data
);

    logic [thrc_pkg::COUNT_W-1:0] down_delay_reg;
    logic [thrc_pkg::COUNT_W-1:0] hold_delay_reg;
    logic [thrc_pkg::COUNT_W-1:0] repeat_period_reg;

    logic [thrc_pkg::COUNT_W-1:0] hold_count_reg;
    logic [thrc_pkg::COUNT_W-1:0] hold_count_next;
    logic [thrc_pkg::COUNT_W-1:0] repeat_phase_reg;
    logic [thrc_pkg::COUNT_W-1:0] repeat_phase_next;
    thrc_pkg::event_kind_t        last_event_reg;
    thrc_pkg::event_kind_t        last_event_next;
    logic [thrc_pkg::COORD_W-1:0] last_x_reg;
    logic [thrc_pkg::COORD_W-1:0] last_x_next;
    logic [thrc_pkg::COORD_W-1:0] last_y_reg;
    logic [thrc_pkg::COORD_W-1:0] last_y_next;

    logic [thrc_pkg::COUNT_W:0]   count_inc;
    logic [thrc_pkg::COUNT_W-1:0] phase_inc;
    logic                         send;
    thrc_pkg::result_t            res;

    logic                         out_valid_reg;
    logic                         skid_valid_reg;
    thrc_pkg::result_t            out_reg;
    thrc_pkg::result_t            skid_reg;

    logic                         in_fire;
    logic                         out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign event_kind = out_reg.kind;
    assign event_x    = out_reg.x;
    assign event_y    = out_reg.y;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_delay_reg    <= thrc_pkg::DOWN_DELAY_RST;
            hold_delay_reg    <= thrc_pkg::HOLD_DELAY_RST;
            repeat_period_reg <= thrc_pkg::REPEAT_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                thrc_pkg::REG_DOWN_DELAY:    down_delay_reg    <= cfg_data;
                thrc_pkg::REG_HOLD_DELAY:    hold_delay_reg    <= cfg_data;
                thrc_pkg::REG_REPEAT_PERIOD: repeat_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-tick classification
    always_comb
    begin
        hold_count_next   = hold_count_reg;
        repeat_phase_next = repeat_phase_reg;
        last_event_next   = last_event_reg;
        last_x_next       = last_x_reg;
        last_y_next       = last_y_reg;
        send              = 1'b0;
        count_inc         = {1'b0, hold_count_reg} + 17'd1;
        phase_inc         = repeat_phase_reg + 16'd1;
        res.kind          = 3'(last_event_reg);
        res.x             = last_x_reg;
        res.y             = last_y_reg;

        if (point_count == 4'd1)
        begin
            last_x_next = touch_x;
            last_y_next = touch_y;
            if (count_inc > {1'b0, thrc_pkg::COUNT_WRAP})
            begin
                hold_count_next   = 16'd1;
                repeat_phase_next = 16'd1;
            end
            else
            begin
                hold_count_next   = count_inc[thrc_pkg::COUNT_W-1:0];
                repeat_phase_next = phase_inc;
            end
            // a zero period lands here every tick, same as a period of one
            if (repeat_phase_next >= repeat_period_reg)
                repeat_phase_next = '0;

            // rules apply in order; the last one that fires wins
            if (hold_count_next >= down_delay_reg && hold_count_next < hold_delay_reg)
            begin
                last_event_next = thrc_pkg::EV_DOWN;
                send            = 1'b1;
            end
            if (hold_count_next >= hold_delay_reg && last_event_next == thrc_pkg::EV_DOWN)
            begin
                last_event_next = thrc_pkg::EV_HOLD;
                send            = 1'b1;
            end
            if (repeat_phase_next == '0 &&
                (last_event_next == thrc_pkg::EV_HOLD ||
                 last_event_next == thrc_pkg::EV_REPEAT))
            begin
                last_event_next = thrc_pkg::EV_REPEAT;
                send            = 1'b1;
            end
            res.kind = 3'(last_event_next);
            res.x    = touch_x;
            res.y    = touch_y;
        end
        else if (point_count == 4'd0)
        begin
            case (last_event_reg)
                thrc_pkg::EV_DOWN:
                begin
                    last_event_next = thrc_pkg::EV_UP_BEFORE;
                    send            = 1'b1;
                end
                thrc_pkg::EV_HOLD, thrc_pkg::EV_REPEAT:
                begin
                    last_event_next = thrc_pkg::EV_UP_AFTER;
                    send            = 1'b1;
                end
                default: ;
            endcase
            // release reports the coordinates held from the last press
            res.kind          = 3'(last_event_next);
            hold_count_next   = '0;
            repeat_phase_next = '0;
            last_x_next       = '0;
            last_y_next       = '0;
        end
    end

    // State update on each tick transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg   <= '0;
            repeat_phase_reg <= '0;
            last_event_reg   <= thrc_pkg::EV_NONE;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
        end
        else if (in_fire)
        begin
            hold_count_reg   <= hold_count_next;
            repeat_phase_reg <= repeat_phase_next;
            last_event_reg   <= last_event_next;
            last_x_reg       <= last_x_next;
            last_y_reg       <= last_y_next;
        end
    end

    // Output register and skid entry: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= in_fire && send;
        end
        else if (in_fire && send)
            skid_valid_reg <= 1'b1;
    end

    // Output register and skid entry: payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_fire && send)
                out_reg <= res;
        end
        else if (in_fire && send)
            skid_reg <= res;
    end

endmodule
